>>> design/assert_macros.svh
// Assertion helpers used by the checker file drsg_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on clk, ignored while rst_n is low.
`define DRSG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("drsg assertion failed");

// Next-cycle implication built on the macro above.
`define DRSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  `DRSG_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

>>> design/drsg_pkg.sv
`default_nettype none
package drsg_pkg;

  localparam int unsigned SLOT_W = 6;
  localparam int unsigned OFS_W  = 4;
  localparam int unsigned RAD_W  = 3;

  typedef enum logic [1:0] {
    DIR_XDN_ZUP,
    DIR_XDN_ZDN,
    DIR_XUP_ZDN,
    DIR_XUP_ZUP
  } drsg_dir_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } drsg_state_e;

  typedef struct packed {
    logic capture;
    logic emit;
  } drsg_cmd_t;

  typedef struct packed {
    logic rescan;
    logic out_free;
    logic last_cell;
  } drsg_sts_t;

  // Slot index of the final cell for a given radius: 2r(r+1).
  function automatic logic [SLOT_W-1:0] ring_last_slot(input logic [RAD_W-1:0] r);
    logic [SLOT_W-1:0] s;
    unique case (r)
      3'd0:    s = 6'd0;
      3'd1:    s = 6'd4;
      3'd2:    s = 6'd12;
      3'd3:    s = 6'd24;
      3'd4:    s = 6'd40;
      3'd5:    s = 6'd60;
      default: s = 6'd60;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> design/drsg_if.sv
`default_nettype none
interface drsg_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [drsg_pkg::RAD_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface drsg_in_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_z;
  logic                         force_req;

  modport source (output valid, output center_x, output center_z, output force_req,
                  input ready);
  modport sink   (input valid, input center_x, input center_z, input force_req,
                  output ready);
endinterface

interface drsg_out_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                              valid;
  logic                              ready;
  logic [drsg_pkg::SLOT_W-1:0]       slot_index;
  logic signed [drsg_pkg::OFS_W-1:0] offset_x;
  logic signed [drsg_pkg::OFS_W-1:0] offset_z;
  logic signed [COORD_BITS-1:0]      cell_x;
  logic signed [COORD_BITS-1:0]      cell_z;
  logic                              last;

  modport source (output valid, output slot_index, output offset_x, output offset_z,
                  output cell_x, output cell_z, output last, input ready);
  modport sink   (input valid, input slot_index, input offset_x, input offset_z,
                  input cell_x, input cell_z, input last, output ready);
endinterface
`default_nettype wire

>>> design/drsg_datapath.sv
`default_nettype none
module drsg_datapath import drsg_pkg::*; #(
  parameter int unsigned MAX_RADIUS = 5,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [RAD_W-1:0]             cfg_data_i,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_z_i,
  input  logic                         force_req_i,
  input  logic                         out_ready_i,
  input  drsg_cmd_t                    cmd_i,
  output drsg_sts_t                    sts_o,
  output logic                         out_valid_o,
  output logic [SLOT_W-1:0]            slot_index_o,
  output logic signed [OFS_W-1:0]      offset_x_o,
  output logic signed [OFS_W-1:0]      offset_z_o,
  output logic signed [COORD_BITS-1:0] cell_x_o,
  output logic signed [COORD_BITS-1:0] cell_z_o,
  output logic                         last_o
);

  localparam logic [RAD_W-1:0] MaxRad = RAD_W'(MAX_RADIUS);

  logic [RAD_W-1:0]             rad_q;
  logic signed [COORD_BITS-1:0] ctr_x_q, ctr_z_q;

  logic [RAD_W-1:0]       ring_q, ring_d;
  logic signed [OFS_W-1:0] ox_q, ox_d, oz_q, oz_d;
  drsg_dir_e              dir_q, dir_d;
  logic [SLOT_W-1:0]      slot_q, last_slot_q;
  logic                   ring_done;

  logic                         out_valid_q, out_valid_d;
  logic [SLOT_W-1:0]            out_slot_q;
  logic signed [OFS_W-1:0]      out_ox_q, out_oz_q;
  logic signed [COORD_BITS-1:0] out_cx_q, out_cz_q;
  logic                         out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q   <= '0;
      ctr_x_q <= '0;
      ctr_z_q <= '0;
    end else begin
      if (cfg_we_i) begin
        rad_q <= (cfg_data_i > MaxRad) ? MaxRad : cfg_data_i;
      end
      if (cmd_i.capture) begin
        ctr_x_q <= center_x_i;
        ctr_z_q <= center_z_i;
      end
    end
  end

  assign sts_o.rescan    = force_req_i || (center_x_i != ctr_x_q) || (center_z_i != ctr_z_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.last_cell = (slot_q == last_slot_q);

  // ring walk stepper
  assign ring_done = (ring_q == '0) ||
                     ((dir_q == DIR_XUP_ZUP) && (oz_q == -OFS_W'(1)));

  always_comb begin
    ring_d = ring_q;
    ox_d   = ox_q;
    oz_d   = oz_q;
    dir_d  = dir_q;
    if (ring_done) begin
      ring_d = ring_q + RAD_W'(1);
      ox_d   = signed'(OFS_W'(ring_q) + OFS_W'(1));
      oz_d   = '0;
      dir_d  = DIR_XDN_ZUP;
    end else begin
      unique case (dir_q)
        DIR_XDN_ZUP: begin
          ox_d = ox_q - OFS_W'(1);
          oz_d = oz_q + OFS_W'(1);
          if (ox_d == '0) dir_d = DIR_XDN_ZDN;
        end
        DIR_XDN_ZDN: begin
          ox_d = ox_q - OFS_W'(1);
          oz_d = oz_q - OFS_W'(1);
          if (oz_d == '0) dir_d = DIR_XUP_ZDN;
        end
        DIR_XUP_ZDN: begin
          ox_d = ox_q + OFS_W'(1);
          oz_d = oz_q - OFS_W'(1);
          if (ox_d == '0) dir_d = DIR_XUP_ZUP;
        end
        default: begin
          ox_d = ox_q + OFS_W'(1);
          oz_d = oz_q + OFS_W'(1);
          if (oz_d == '0) dir_d = DIR_XDN_ZUP;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ring_q      <= '0;
      ox_q        <= '0;
      oz_q        <= '0;
      dir_q       <= DIR_XDN_ZUP;
      slot_q      <= '0;
      last_slot_q <= ring_last_slot(rad_q);
    end else if (cmd_i.emit) begin
      ring_q <= ring_d;
      ox_q   <= ox_d;
      oz_q   <= oz_d;
      dir_q  <= dir_d;
      slot_q <= slot_q + SLOT_W'(1);
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_slot_q <= slot_q;
      out_ox_q   <= ox_q;
      out_oz_q   <= oz_q;
      out_cx_q   <= ctr_x_q + COORD_BITS'(ox_q);
      out_cz_q   <= ctr_z_q + COORD_BITS'(oz_q);
      out_last_q <= (slot_q == last_slot_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign slot_index_o = out_slot_q;
  assign offset_x_o   = out_ox_q;
  assign offset_z_o   = out_oz_q;
  assign cell_x_o     = out_cx_q;
  assign cell_z_o     = out_cz_q;
  assign last_o       = out_last_q;

endmodule
`default_nettype wire

>>> design/drsg_ctrl.sv
`default_nettype none
module drsg_ctrl import drsg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  drsg_sts_t sts_i,
  output drsg_cmd_t cmd_o
);

  drsg_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.rescan) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.out_free && sts_i.last_cell) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.emit    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i && sts_i.rescan;
      end
      ST_SCAN: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> design/diamond_ring_scan_generator_core.sv
// An item is accepted and its centre captured in the idle state; the single ring-walk
// stepper then emits one cell per cycle in the scan state while the output is free,
// 2r(r+1)+1 cells a rescan (61 at radius 5); an unchanged unforced centre is not scanned.
// A new item is taken while the final cell still waits in the output register.
// Reset: radius 0, stored centre 0, controller idle, output empty.
`default_nettype none
module diamond_ring_scan_generator_core import drsg_pkg::*; #(
  parameter int unsigned MAX_RADIUS = 5,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  drsg_cfg_if.sink   cfg_i,
  drsg_in_if.sink    in_i,
  drsg_out_if.source out_o
);

  drsg_cmd_t cmd;
  drsg_sts_t sts;

  assign cfg_i.ready = 1'b1;

  drsg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  drsg_datapath #(
    .MAX_RADIUS (MAX_RADIUS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_i.valid),
    .cfg_data_i   (cfg_i.data),
    .center_x_i   (in_i.center_x),
    .center_z_i   (in_i.center_z),
    .force_req_i  (in_i.force_req),
    .out_ready_i  (out_o.ready),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_o.valid),
    .slot_index_o (out_o.slot_index),
    .offset_x_o   (out_o.offset_x),
    .offset_z_o   (out_o.offset_z),
    .cell_x_o     (out_o.cell_x),
    .cell_z_o     (out_o.cell_z),
    .last_o       (out_o.last)
  );

endmodule
`default_nettype wire

>>> design/drsg_checker.sv
`default_nettype none
`include "assert_macros.svh"
module drsg_checker import drsg_pkg::*; #(
  parameter int unsigned COORD_BITS = 24
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [SLOT_W-1:0]            slot_index_i,
  input logic signed [OFS_W-1:0]      offset_x_i,
  input logic signed [OFS_W-1:0]      offset_z_i,
  input logic signed [COORD_BITS-1:0] cell_x_i,
  input logic                         last_i
);

  `DRSG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(cell_x_i))
  `DRSG_ASSERT_NEXT(a_slot_seq, clk_i, rst_ni, out_valid_i && out_ready_i && !last_i, out_valid_i && (slot_index_i == $past(slot_index_i) + 6'd1))
  `DRSG_ASSERT(a_center_first, clk_i, rst_ni, (out_valid_i && (slot_index_i == '0)) |-> ((offset_x_i == '0) && (offset_z_i == '0)))
  `DRSG_ASSERT(a_busy_no_take, clk_i, rst_ni, (out_valid_i && !last_i) |-> !in_ready_i)

endmodule

bind diamond_ring_scan_generator_core drsg_checker #(
  .COORD_BITS (COORD_BITS)
) u_drsg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .slot_index_i (out_o.slot_index),
  .offset_x_i   (out_o.offset_x),
  .offset_z_i   (out_o.offset_z),
  .cell_x_i     (out_o.cell_x),
  .last_i       (out_o.last)
);
`default_nettype wire

>>> bench/diamond_ring_scan_generator_core_tb.sv
`timescale 1ns / 1ps
module diamond_ring_scan_generator_core_tb;
  import drsg_pkg::*;

  localparam int unsigned COORD_BITS = 24;
  localparam int          MAX_RAD    = 5;
  localparam int          DRAIN_CAP  = 2000;
  localparam int          SETTLE     = 4;

  typedef struct packed {
    logic [SLOT_W-1:0]            slot;
    logic signed [OFS_W-1:0]      ofs_x;
    logic signed [OFS_W-1:0]      ofs_z;
    logic signed [COORD_BITS-1:0] cell_x;
    logic signed [COORD_BITS-1:0] cell_z;
    logic                         last;
  } scan_cell_t;

  logic clk_i;
  logic rst_ni;

  drsg_cfg_if                            cfg_if ();
  drsg_in_if  #(.COORD_BITS(COORD_BITS)) in_if ();
  drsg_out_if #(.COORD_BITS(COORD_BITS)) out_if ();

  diamond_ring_scan_generator_core #(
    .MAX_RADIUS(MAX_RAD),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  scan_cell_t            expected_cells[$];
  logic [RAD_W-1:0]      scan_radius;
  logic [COORD_BITS-1:0] held_x;
  logic [COORD_BITS-1:0] held_z;
  int                    errors;
  bit                    idle_on;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Ring walk: start at (r,0), turn when the coordinate heading to zero gets there.
  function automatic void predict_scan(input logic [COORD_BITS-1:0] cx,
                                       input logic [COORD_BITS-1:0] cz,
                                       input logic frc);
    int         rad;
    int         ox;
    int         oz;
    int         count;
    int         slot;
    int         total;
    drsg_dir_e  dir;
    scan_cell_t c;
    if (!frc && cx == held_x && cz == held_z) return;
    held_x = cx;
    held_z = cz;
    rad = (scan_radius > MAX_RAD) ? MAX_RAD : int'(scan_radius);
    total = 2 * rad * (rad + 1) + 1;
    slot = 0;
    for (int r = 0; r <= rad; r++) begin
      ox = r;
      oz = 0;
      dir = DIR_XDN_ZUP;
      count = (r == 0) ? 1 : 4 * r;
      for (int j = 0; j < count; j++) begin
        c.slot   = SLOT_W'(slot);
        c.ofs_x  = OFS_W'(ox);
        c.ofs_z  = OFS_W'(oz);
        c.cell_x = cx + COORD_BITS'(ox);
        c.cell_z = cz + COORD_BITS'(oz);
        c.last   = (slot + 1 == total);
        expected_cells.push_back(c);
        slot++;
        case (dir)
          DIR_XDN_ZUP: begin
            ox--; oz++;
            if (ox == 0) dir = DIR_XDN_ZDN;
          end
          DIR_XDN_ZDN: begin
            ox--; oz--;
            if (oz == 0) dir = DIR_XUP_ZDN;
          end
          DIR_XUP_ZDN: begin
            ox++; oz--;
            if (ox == 0) dir = DIR_XUP_ZUP;
          end
          default: begin
            ox++; oz++;
            if (oz == 0) dir = DIR_XDN_ZUP;
          end
        endcase
      end
    end
  endfunction

  function automatic void flag_field(input string fname, input logic [COORD_BITS-1:0] want,
                                     input logic [COORD_BITS-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    scan_cell_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_cells.size() == 0) begin
        errors++;
        $display("%0t: unexpected cell, expected none actual slot %0d", $time,
                 out_if.slot_index);
      end else begin
        want = expected_cells.pop_front();
        flag_field("slot_index", COORD_BITS'(want.slot), COORD_BITS'(out_if.slot_index));
        flag_field("offset_x", COORD_BITS'({want.ofs_x}), COORD_BITS'({out_if.offset_x}));
        flag_field("offset_z", COORD_BITS'({want.ofs_z}), COORD_BITS'({out_if.offset_z}));
        flag_field("cell_x", want.cell_x, out_if.cell_x);
        flag_field("cell_z", want.cell_z, out_if.cell_z);
        flag_field("last", COORD_BITS'(want.last), COORD_BITS'(out_if.last));
      end
    end
  end

  // Sink side: random stall before each cell while idle_on is set.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_on ? $urandom_range(0, 7) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  task automatic send_center(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] z,
                             input logic frc);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.center_x  <= x;
    in_if.center_z  <= z;
    in_if.force_req <= frc;
    do @(posedge clk_i); while (!in_if.ready);
    predict_scan(x, z, frc);
  endtask

  task automatic drain_results();
    int waited;
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    waited = 0;
    while (expected_cells.size() != 0 && waited < DRAIN_CAP) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_cells.size() != 0) begin
      errors++;
      $display("%0t: %0d expected cells never arrived", $time, expected_cells.size());
      expected_cells.delete();
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [RAD_W-1:0] r);
    drain_results();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= r;
    do @(posedge clk_i); while (!cfg_if.ready);
    scan_radius = r;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    idle_on = 1'b1;
    send_center('0, '0, 1'b0);
    send_center('0, '0, 1'b1);
  endtask

  task automatic test_radius_sweep();
    for (int r = 0; r < 8; r++) begin
      write_radius(RAD_W'(r));
      if (r % 2 == 0)
        send_center(held_x, held_z, 1'b1);
      else
        send_center(COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b0);
    end
  endtask

  task automatic test_center_wrap();
    write_radius(RAD_W'(MAX_RAD));
    idle_on = 1'b0;
    send_center(24'h7FFFFF, 24'h800000, 1'b0);
    send_center(24'h800000, 24'h7FFFFF, 1'b0);
    send_center(24'hFFFFFF, 24'h000000, 1'b0);
    send_center(24'hFFFFFF, 24'h000000, 1'b0);
    send_center(24'hFFFFFF, 24'h000001, 1'b0);
    send_center(24'h000000, 24'h000001, 1'b0);
    send_center(24'h000000, 24'h000001, 1'b1);
    idle_on = 1'b1;
  endtask

  task automatic test_random_scans();
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] z;
    logic [COORD_BITS-1:0] corner;
    logic                  frc;
    int                    sel;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       write_radius(RAD_W'(MAX_RAD));
        1:       write_radius('0);
        2:       write_radius('1);
        default: write_radius(RAD_W'($urandom_range(0, 7)));
      endcase
      idle_on = (phase % 3 != 2);
      for (int n = 0; n < 52; n++) begin
        sel = $urandom_range(0, 9);
        x = held_x;
        z = held_z;
        frc = 1'b0;
        case (sel)
          0, 1: ;
          2, 3: frc = 1'b1;
          4, 5: begin
            x = COORD_BITS'($urandom);
            z = COORD_BITS'($urandom);
            frc = 1'($urandom_range(0, 1));
          end
          6, 7: begin
            x = held_x + COORD_BITS'($urandom_range(0, 2)) - 1'b1;
            z = held_z + COORD_BITS'($urandom_range(0, 2)) - 1'b1;
            frc = 1'($urandom_range(0, 1));
          end
          8: begin
            if ($urandom_range(0, 1)) x = COORD_BITS'($urandom);
            else z = COORD_BITS'($urandom);
          end
          default: begin
            case ($urandom_range(0, 3))
              0:       corner = 24'h7FFFFF;
              1:       corner = 24'h800000;
              2:       corner = 24'hFFFFFF;
              default: corner = 24'h000000;
            endcase
            x = corner + COORD_BITS'($urandom_range(0, 10)) - 24'd5;
            z = ~corner + COORD_BITS'($urandom_range(0, 10)) - 24'd5;
            frc = 1'($urandom_range(0, 1));
          end
        endcase
        if ($urandom_range(0, 24) == 0)
          drain_results();
        send_center(x, z, frc);
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    in_if.valid     = 1'b0;
    in_if.center_x  = '0;
    in_if.center_z  = '0;
    in_if.force_req = 1'b0;
    scan_radius     = '0;
    held_x          = '0;
    held_z          = '0;
    errors          = 0;
    idle_on         = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_radius_sweep();
    test_center_wrap();
    test_random_scans();
    drain_results();

    if (errors == 0) begin
      $display("diamond_ring_scan_generator_core regression: pass");
    end else begin
      $display("diamond_ring_scan_generator_core regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("diamond_ring_scan_generator_core regression: fail");
    $finish;
  end

endmodule

>>> diamond_ring_scan_generator_core.f
+incdir+design
design/drsg_pkg.sv
design/drsg_if.sv
design/drsg_datapath.sv
design/drsg_ctrl.sv
design/diamond_ring_scan_generator_core.sv
design/drsg_checker.sv
bench/diamond_ring_scan_generator_core_tb.sv
